FILE: sv/record_fifo_with_age_average_assert.svh
// assertion macros for the record queue
`ifndef RECORD_FIFO_WITH_AGE_AVERAGE_ASSERT_SVH
`define RECORD_FIFO_WITH_AGE_AVERAGE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record queue check failed");

// condition holds in the cycle after the trigger
`define RFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record queue check failed");

`endif

FILE: sv/rfa_pkg.sv
// shared types and constants of the record queue
package rfa_pkg;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 27;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     removed_id;
    logic [AGE_W-1:0]    removed_age;
    logic [COUNT_W-1:0]  entry_count;
    logic [AGE_W-1:0]    average_age;
  } rsp_t;

endpackage

FILE: sv/rfa_if.sv
// request and response channels of the record queue
interface rfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [rfa_pkg::MODE_W-1:0]  mode;
  logic [rfa_pkg::ID_W-1:0]    record_id;
  logic [rfa_pkg::AGE_W-1:0]   record_age;

  modport source (output valid, mode, record_id, record_age, input ready);
  modport sink (input valid, mode, record_id, record_age, output ready);
endinterface

interface rfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rfa_pkg::STATUS_W-1:0]  status;
  logic [rfa_pkg::ID_W-1:0]      removed_id;
  logic [rfa_pkg::AGE_W-1:0]     removed_age;
  logic [rfa_pkg::COUNT_W-1:0]   entry_count;
  logic [rfa_pkg::AGE_W-1:0]     average_age;

  modport source (output valid, status, removed_id, removed_age, entry_count, average_age,
                  input ready);
  modport sink (input valid, status, removed_id, removed_age, entry_count, average_age,
                output ready);
endinterface

FILE: sv/record_fifo_with_age_average.sv
// record queue top level: ring store, running age sum, iterative average
//
//  channel  dir  payload                                                  handshake
//  req      in   mode, record_id, record_age                               valid/ready
//  rsp      out  status, removed_id, removed_age, entry_count, average_age valid/ready
//
// one request at a time; an enqueue or a refused request goes from idle to hold, a
// dequeue reads the ram in S_READ, an average query runs S_DIV, one quotient bit per
// cycle from a shared compare and subtract
// a finished word waits in the output register while the next request is taken
// rst is synchronous and empties the queue; store contents are left as they are
`include "record_fifo_with_age_average_assert.svh"

module record_fifo_with_age_average #(
  parameter int QUEUE_DEPTH = rfa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  rfa_req_if.sink    req,
  rfa_rsp_if.source  rsp
);

  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int SW      = rfa_pkg::AGE_W + CW;
  localparam int DW      = rfa_pkg::ID_W + rfa_pkg::AGE_W;
  localparam int QW      = rfa_pkg::AGE_W;
  localparam int STEP_W  = $clog2(QW);
  localparam logic [AW-1:0]     LAST_SLOT  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]     FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(QW - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]          state;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [SW-1:0]       age_sum;
  logic [SW-1:0]       rem;
  logic [SW-1:0]       dvs;
  logic [QW-1:0]       quot;
  logic [STEP_W-1:0]   step;
  rfa_pkg::rsp_t       res;
  rfa_pkg::rsp_t       out_data;
  logic                out_valid;

  logic                accept;
  logic                full;
  logic                empty;
  logic                load;
  logic                ge;
  logic [QW-1:0]       quot_next;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;
  logic [AW-1:0]       head_next;
  logic [AW-1:0]       tail_next;
  logic                ram_we;
  logic [DW-1:0]       ram_rdata;

  assign accept    = req.valid && req.ready;
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign load      = (state == S_HOLD) && (!out_valid || rsp.ready);
  assign ge        = (rem >= dvs);
  assign quot_next = {quot[QW-2:0], ge};
  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;
  assign head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign ram_we    = accept && (req.mode == rfa_pkg::MODE_ENQ) && !full;

  assign req.ready = (state == S_IDLE);

  rfa_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({req.record_id, req.record_age}),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      age_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.removed_id  <= '0;
            res.removed_age <= '0;
            res.average_age <= '0;
            unique case (req.mode)
              rfa_pkg::MODE_ENQ: begin
                state <= S_HOLD;
                if (full) begin
                  res.status      <= rfa_pkg::ST_FULL;
                  res.entry_count <= rfa_pkg::COUNT_W'(count);
                end else begin
                  res.status      <= rfa_pkg::ST_DONE;
                  tail            <= tail_next;
                  count           <= count_inc;
                  age_sum         <= age_sum + SW'(req.record_age);
                  res.entry_count <= rfa_pkg::COUNT_W'(count_inc);
                end
              end
              rfa_pkg::MODE_DEQ: begin
                if (empty) begin
                  res.status      <= rfa_pkg::ST_EMPTY;
                  res.entry_count <= rfa_pkg::COUNT_W'(count);
                  state           <= S_HOLD;
                end else begin
                  res.status <= rfa_pkg::ST_DONE;
                  state      <= S_READ;
                end
              end
              rfa_pkg::MODE_AVG: begin
                res.entry_count <= rfa_pkg::COUNT_W'(count);
                if (empty) begin
                  res.status <= rfa_pkg::ST_EMPTY;
                  state      <= S_HOLD;
                end else begin
                  res.status <= rfa_pkg::ST_DONE;
                  rem        <= age_sum;
                  dvs        <= SW'(count) << (QW - 1);
                  quot       <= '0;
                  step       <= '0;
                  state      <= S_DIV;
                end
              end
              default: begin
                res.status      <= rfa_pkg::ST_DONE;
                res.entry_count <= rfa_pkg::COUNT_W'(count);
                state           <= S_HOLD;
              end
            endcase
          end
        end
        S_READ: begin
          res.removed_id  <= ram_rdata[DW-1:rfa_pkg::AGE_W];
          res.removed_age <= ram_rdata[rfa_pkg::AGE_W-1:0];
          res.entry_count <= rfa_pkg::COUNT_W'(count_dec);
          head            <= head_next;
          count           <= count_dec;
          age_sum         <= age_sum - SW'(ram_rdata[rfa_pkg::AGE_W-1:0]);
          state           <= S_HOLD;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dvs;
          end
          quot <= quot_next;
          dvs  <= dvs >> 1;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            res.average_age <= quot_next;
            state           <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_data.status;
  assign rsp.removed_id  = out_data.removed_id;
  assign rsp.removed_age = out_data.removed_age;
  assign rsp.entry_count = out_data.entry_count;
  assign rsp.average_age = out_data.average_age;

  `RFA_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_COUNT)
  `RFA_ASSERT_NOW(a_sum_empty, count == '0, age_sum == '0)
  `RFA_ASSERT_NEXT(a_enq_count, ram_we, count == $past(count) + 1'b1)
  `RFA_ASSERT_NEXT(a_load_valid, load, rsp.valid && state == S_IDLE)

endmodule

FILE: sv/rfa_ram.sv
// generic single write port ram with registered read
module rfa_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = rfa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/record_fifo_with_age_average_test.sv
// self-checking testbench for the record queue: directed script, then random requests
module record_fifo_with_age_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfa_pkg::*;

  localparam int RECORD_SLOTS = DEFAULT_QUEUE_DEPTH;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ID_W-1:0] ID_TOP = 27'd99999999;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 420;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } person_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    int                reps;
    bit                typed;
    rsp_t              want;
  } script_row_t;

  logic clk;
  logic rst;

  rfa_req_if req_ch();
  rfa_rsp_if rsp_ch();

  record_fifo_with_age_average dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  person_t      shadow_queue[$];
  logic [11:0]  shadow_age_sum;
  rsp_t         expected_words[$];
  script_row_t  opening[$];
  int           errors;
  int           stalled_cycles;
  int           req_idle_pct;
  int           rsp_idle_pct;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic rsp_t predict_response(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                            logic [AGE_W-1:0] age);
    rsp_t    r;
    person_t p;
    r = '0;
    case (mode)
      MODE_ENQ: begin
        if (shadow_queue.size() >= RECORD_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          p.id = id;
          p.age = age;
          shadow_queue.push_back(p);
          shadow_age_sum += age;
        end
      end
      MODE_DEQ: begin
        if (shadow_queue.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          p = shadow_queue.pop_front();
          r.removed_id = p.id;
          r.removed_age = p.age;
          shadow_age_sum -= p.age;
        end
      end
      MODE_AVG: begin
        if (shadow_queue.size() == 0) r.status = ST_EMPTY;
        else r.average_age = AGE_W'(shadow_age_sum / shadow_queue.size());
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_queue.size());
    return r;
  endfunction

  function automatic void add_row(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                  logic [AGE_W-1:0] age, int reps, bit typed, rsp_t want);
    script_row_t row;
    row.mode = mode;
    row.id = id;
    row.age = age;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    opening.push_back(row);
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // one request word: random hold-off, then hold valid until taken
  task automatic send_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                              logic [AGE_W-1:0] age, bit typed, rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.record_id <= id;
    req_ch.record_age <= age;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_response(mode, id, age);
    expected_words.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word expected none actual %0h", $time,
                 {rsp_ch.status, rsp_ch.removed_id, rsp_ch.removed_age,
                  rsp_ch.entry_count, rsp_ch.average_age});
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("removed_id", want.removed_id, rsp_ch.removed_id);
        check_field("removed_age", want.removed_age, rsp_ch.removed_age);
        check_field("entry_count", want.entry_count, rsp_ch.entry_count);
        check_field("average_age", want.average_age, rsp_ch.average_age);
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int               counted;
    int               burst_left;
    int               enq_pct;
    int               pick;
    int               enq_bias[3];
    int               phase;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;

    enq_bias = '{85, 50, 15};
    shadow_age_sum = '0;
    req_idle_pct = 27;
    rsp_idle_pct = 57;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_ENQ;
    req_ch.record_id <= '0;
    req_ch.record_age <= '0;

    add_row(MODE_DEQ, '1, '1, 1, 1, '{ST_EMPTY, 27'd0, 8'd0, 5'd0, 8'd0});
    add_row(MODE_AVG, '1, '1, 1, 1, '{ST_EMPTY, 27'd0, 8'd0, 5'd0, 8'd0});
    add_row(MODE_UNUSED, '1, '1, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd0, 8'd0});
    add_row(MODE_ENQ, '1, 8'd255, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd1, 8'd0});
    add_row(MODE_ENQ, '0, 8'd0, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd2, 8'd0});
    add_row(MODE_AVG, '0, '0, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd2, 8'd127});
    add_row(MODE_DEQ, '0, '0, 1, 1, '{ST_DONE, 27'h7FFFFFF, 8'd255, 5'd1, 8'd0});
    add_row(MODE_DEQ, '0, '0, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd0, 8'd0});
    // fill to the brim with the oldest possible ages
    add_row(MODE_ENQ, ID_TOP - 27'd15, 8'd255, RECORD_SLOTS, 0, '0);
    add_row(MODE_ENQ, '1, '1, 1, 1, '{ST_FULL, 27'd0, 8'd0, 5'd16, 8'd0});
    add_row(MODE_AVG, '0, '0, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd16, 8'd255});
    add_row(MODE_UNUSED, '0, '0, 1, 1, '{ST_DONE, 27'd0, 8'd0, 5'd16, 8'd0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) begin
      for (int k = 0; k < opening[i].reps; k++) begin
        send_request(opening[i].mode, opening[i].id + ID_W'(k), opening[i].age,
                     opening[i].typed, opening[i].want);
      end
    end

    burst_left = 0;
    enq_pct = 50;
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          req_idle_pct = 27;
          rsp_idle_pct = 57;
        end
        1: begin
          req_idle_pct = 57;
          rsp_idle_pct = 27;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // bursts lean toward filling or emptying so both ends get visited
        if (burst_left == 0) begin
          burst_left = $urandom_range(8, 40);
          enq_pct = enq_bias[$urandom_range(2)];
        end
        burst_left--;
        if ($urandom_range(99) < enq_pct) begin
          mode = MODE_ENQ;
        end else begin
          pick = $urandom_range(99);
          mode = (pick < 3) ? MODE_UNUSED : (pick < 28) ? MODE_AVG : MODE_DEQ;
        end
        case ($urandom_range(9))
          0: id = '0;
          1: id = '1;
          2: id = ID_TOP;
          3: id = ID_W'($urandom);
          default: id = ID_W'($urandom_range(0, 99999999));
        endcase
        case ($urandom_range(7))
          0: age = '0;
          1: age = '1;
          default: age = AGE_W'($urandom_range(255));
        endcase
        send_request(mode, id, age, 0, '0);
        if (mode != MODE_UNUSED) counted++;
        if ($urandom_range(149) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
